// ===== sv/heartbeat_command_listener_assert.svh =====
// Assertion macros shared by the heartbeat command listener RTL.
`ifndef HEARTBEAT_COMMAND_LISTENER_ASSERT_SVH
`define HEARTBEAT_COMMAND_LISTENER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HCL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/hcl_pkg.sv =====
// Types and constants for the heartbeat command listener.
`timescale 1ns / 1ps
`default_nettype none

package hcl_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_COMMAND   = 2'd1,
      OP_HEARTBEAT = 2'd2,
      OP_RESERVED  = 2'd3
   } op_type;

   // Result kinds
   typedef enum logic {
      KIND_PLAY  = 1'b0,
      KIND_REPLY = 1'b1
   } kind_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_MY_ID      = 2'd0,
      CSR_TIMEOUT    = 2'd1,
      CSR_RATE_MIN   = 2'd2,
      CSR_RATE_MAX   = 2'd3
   } csr_index_type;

   localparam logic [7:0]  BROADCAST_ID       = 8'd255;
   localparam logic [15:0] CMD_SET_SOURCE     = 16'd6;
   localparam logic [15:0] CMD_SET_OFFSET     = 16'd15;
   localparam logic [15:0] CMD_IDENTIFY       = 16'd16;
   localparam logic [15:0] CMD_IDENTIFY_REPLY = 16'd17;

   localparam logic [7:0] SECONDS_MAX       = 8'd255;
   localparam logic [7:0] RESET_MY_ID       = 8'd0;
   localparam logic [7:0] RESET_TIMEOUT     = 8'd5;
   localparam logic [7:0] RESET_RATE_MIN    = 8'd30;
   localparam logic [7:0] RESET_RATE_MAX    = 8'd200;

   typedef struct packed {
      op_type              operation;
      logic                packet_complete;
      logic [7:0]          target_id;
      logic [7:0]          tracking_id;
      logic [15:0]         command_code;
      logic signed [31:0]  cmd_arg;
      logic [7:0]          pod_id;
      logic [23:0]         bpm_q8;
      logic [31:0]         beat_age_ms;
   } req_type;

   typedef struct packed {
      kind_type            result_kind;
      logic [7:0]          play_rate;
      logic [31:0]         play_delay_ms;
      logic                rate_was_clamped;
      logic [7:0]          reply_receiver;
      logic [7:0]          reply_tracking_id;
      logic [15:0]         reply_command_code;
      logic signed [31:0]  reply_data;
      logic                fallback_active;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/heartbeat_command_listener.sv =====
// Heartbeat command listener: command decode, heartbeat gating and fallback timer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request beat per cycle while req_stall is low (tick, command or
// heartbeat) and produces at most one registered response beat. All decode,
// clamp and offset add happen in one combinational pass from the request port
// into the response or skid register, and the state (source, offset, fallback
// flag, seconds counter) updates at the same edge, so the next beat may follow
// directly. A two-entry output (response register plus skid register) lets a
// new beat be accepted while a result waits; req_stall rises only when both
// hold data. Configuration writes are expected only while no beat is in flight.
module heartbeat_command_listener
   import hcl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_type       req_data,
   // response channel
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data,
   // configuration port
   input  wire logic          csr_write_enable,
   input  wire csr_index_type csr_index,
   input  wire logic [7:0]    csr_write_data
);

   // configuration
   logic [7:0] my_id_ff,    my_id_in;
   logic [7:0] timeout_ff,  timeout_in;
   logic [7:0] rate_min_ff, rate_min_in;
   logic [7:0] rate_max_ff, rate_max_in;

   // listener state
   logic [7:0]  source_ff,   source_in;
   logic [15:0] offset_ff,   offset_in;
   logic        fallback_ff, fallback_in;
   logic [7:0]  seconds_ff,  seconds_in;

   // output buffering
   logic    rsp_valid_ff,  rsp_valid_in;
   rsp_type rsp_data_ff,   rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff,  skid_data_in;

   logic        accept;
   logic        rsp_take;
   logic [7:0]  seconds_tick;
   logic        fallback_chk;
   logic        addr_ok;
   logic        from_source;
   logic        hb_ok;
   logic [15:0] rate_int;
   logic        rate_low;
   logic        rate_high;
   logic [15:0] rate_raised;
   logic [31:0] offset_sext;
   logic        has_result;
   rsp_type     result;

   assign accept   = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // timeout check, ahead of acting on the beat
   assign seconds_tick = (req_data.operation == OP_TICK && seconds_ff != SECONDS_MAX)
                         ? seconds_ff + 8'd1 : seconds_ff;
   assign fallback_chk = fallback_ff || (seconds_tick >= timeout_ff);

   // command and heartbeat qualifiers
   assign addr_ok     = (req_data.target_id == my_id_ff) ||
                        (req_data.target_id == BROADCAST_ID);
   assign from_source = (req_data.pod_id == source_ff);
   assign hb_ok       = (req_data.bpm_q8 != 24'd0) &&
                        (from_source || (fallback_chk && req_data.pod_id == 8'd0));

   // integer rate and clamp; crossed bounds settle on rate_max
   assign rate_int    = req_data.bpm_q8[23:8];
   assign rate_low    = rate_int < {8'd0, rate_min_ff};
   assign rate_high   = rate_int > {8'd0, rate_max_ff};
   assign rate_raised = rate_low ? {8'd0, rate_min_ff} : rate_int;
   assign offset_sext = {{16{offset_ff[15]}}, offset_ff};

   // per-beat decode and state update
   always_comb begin
      source_in   = source_ff;
      offset_in   = offset_ff;
      fallback_in = fallback_chk;
      seconds_in  = seconds_tick;
      has_result  = 1'b0;
      result      = '0;
      if (req_data.packet_complete && req_data.operation == OP_COMMAND && addr_ok) begin
         case (req_data.command_code)
            CMD_SET_SOURCE: begin
               source_in = req_data.cmd_arg[7:0];
            end
            CMD_SET_OFFSET: begin
               offset_in = req_data.cmd_arg[15:0];
            end
            CMD_IDENTIFY: begin
               has_result                = 1'b1;
               result.result_kind        = KIND_REPLY;
               result.reply_receiver     = BROADCAST_ID;
               result.reply_tracking_id  = req_data.tracking_id;
               result.reply_command_code = CMD_IDENTIFY_REPLY;
               result.reply_data         = {my_id_ff | {8{offset_ff[15]}},
                                            offset_ff, source_ff};
               result.fallback_active    = fallback_chk;
            end
            default: ;
         endcase
      end
      if (req_data.packet_complete && req_data.operation == OP_HEARTBEAT && hb_ok) begin
         if (from_source) begin
            fallback_in = 1'b0;
            seconds_in  = 8'd0;
         end
         has_result              = 1'b1;
         result.result_kind      = KIND_PLAY;
         result.play_rate        = (rate_raised > {8'd0, rate_max_ff})
                                   ? rate_max_ff : rate_raised[7:0];
         result.play_delay_ms    = req_data.beat_age_ms + offset_sext;
         result.rate_was_clamped = rate_low || rate_high;
         result.fallback_active  = from_source ? 1'b0 : fallback_chk;
      end
   end

   // next state of the configuration registers: configuration writes
   always_comb begin
      my_id_in    = my_id_ff;
      timeout_in  = timeout_ff;
      rate_min_in = rate_min_ff;
      rate_max_in = rate_max_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MY_ID:    my_id_in    = csr_write_data;
            CSR_TIMEOUT:  timeout_in  = csr_write_data;
            CSR_RATE_MIN: rate_min_in = csr_write_data;
            CSR_RATE_MAX: rate_max_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // response register plus skid stage
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && has_result) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_ff      <= RESET_MY_ID;
         timeout_ff    <= RESET_TIMEOUT;
         rate_min_ff   <= RESET_RATE_MIN;
         rate_max_ff   <= RESET_RATE_MAX;
         source_ff     <= RESET_MY_ID;
         offset_ff     <= 16'd0;
         fallback_ff   <= 1'b0;
         seconds_ff    <= SECONDS_MAX;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         my_id_ff      <= my_id_in;
         timeout_ff    <= timeout_in;
         rate_min_ff   <= rate_min_in;
         rate_max_ff   <= rate_max_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_write_enable && csr_index == CSR_MY_ID) begin
            source_ff <= csr_write_data;
         end else if (accept) begin
            source_ff <= source_in;
         end
         if (accept) begin
            offset_ff   <= offset_in;
            fallback_ff <= fallback_in;
            seconds_ff  <= seconds_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
`include "heartbeat_command_listener_assert.svh"

   `HCL_ASSERT_IMPLY(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff,
      "skid holds data while response register is empty")
   `HCL_ASSERT_NEXT(a_source_beat_clears, clock, reset,
      accept && !csr_write_enable && req_data.packet_complete &&
      req_data.operation == OP_HEARTBEAT && hb_ok && from_source,
      !fallback_ff && seconds_ff == 8'd0,
      "source heartbeat did not clear fallback timer")
   `HCL_ASSERT_NEXT(a_rsp_drains, clock, reset,
      rsp_take && !skid_valid_ff && !(accept && has_result), !rsp_valid_ff,
      "taken response beat not retired")
   `HCL_ASSERT_NEXT(a_skid_fill, clock, reset,
      rsp_valid_ff && rsp_stall && !skid_valid_ff && accept && has_result,
      skid_valid_ff && rsp_valid_ff, "result lost while response stalled")

endmodule

`default_nettype wire
